// File: rtl/rtt_pkg.sv
// shared types, constants and codes for the request tag table
package rtt_pkg;

    localparam int DEPTH_DEFAULT = 32;

    localparam logic [14:0] SEQ_RESET    = 15'd2;
    localparam logic [15:0] EXPIRY_RESET = 16'd60;

    localparam logic [2:0] KIND_ALLOC       = 3'd0;
    localparam logic [2:0] KIND_GENERATE    = 3'd1;
    localparam logic [2:0] KIND_FIND_TAG    = 3'd2;
    localparam logic [2:0] KIND_FIND_OPAQUE = 3'd3;
    localparam logic [2:0] KIND_FREE        = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] ident;
        logic [31:0] user_id;
        logic [31:0] opaque_value;
        logic [31:0] tag_in;
        logic [31:0] now_seconds;
    } rtt_req_t;

    typedef struct packed {
        logic [31:0] tag_out;
        logic        found;
        logic [31:0] user_out;
        logic [31:0] opaque_out;
        logic        full_flag;
    } rtt_res_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] user;
        logic [31:0] opaque;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic keep;
    } cell_ctl_t;

endpackage

// File: rtl/rtt_if.sv
// request and response channel interfaces
interface rtt_req_if import rtt_pkg::*; ();
    logic     valid;
    logic     ready;
    rtt_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rtt_rsp_if import rtt_pkg::*; ();
    logic     valid;
    logic     ready;
    rtt_res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/rtt_cell.sv
// one table cell holding a single entry, loads new data or takes from its neighbor or from cell 0
module rtt_cell import rtt_pkg::*; #(
    parameter int INDEX = 0,
    parameter int IDX_W = 5
) (
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] pos,
    input  entry_t           new_entry,
    input  entry_t           next_entry,
    input  entry_t           head_entry,
    output entry_t           entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   at_pos;

    assign at_pos = (pos == IDX_W'(INDEX));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load && at_pos)
        begin
            entry_next = new_entry;
        end
        else if (ctl.rotate)
        begin
            if (ctl.keep && at_pos)
            begin
                entry_next = head_entry;
            end
            else
            begin
                entry_next = next_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/rtt_ctrl.sv
// sequencer: tag generation, fill count, scan of the cell row and result register
module rtt_ctrl import rtt_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT,
    parameter int IDX_W       = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtt_req_t         in_req,
    output logic             out_valid,
    input  logic             out_ready,
    output rtt_res_t         out_res,
    input  logic [15:0]      expiry,
    input  entry_t           head,
    output cell_ctl_t        ctl,
    output logic [IDX_W-1:0] pos,
    output entry_t           new_entry,
    output logic [CNT_W-1:0] count
);

    state_t           state_reg, state_next;
    rtt_req_t         req_reg, req_next;
    rtt_res_t         res_reg, res_next;
    rtt_res_t         out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [14:0]      seq_reg, seq_next;
    logic             matched_reg, matched_next;
    logic [31:0]      new_tag;
    logic [31:0]      limit;
    logic             expired;
    logic             is_full;

    assign new_tag = {req_reg.ident, 1'b0, seq_reg};
    assign limit   = head.stamp + {16'd0, expiry};
    assign expired = (limit < req_reg.now_seconds);
    assign is_full = (cnt_reg == CNT_W'(TABLE_DEPTH));

    assign new_entry = '{tag: new_tag, user: req_reg.user_id,
                         opaque: req_reg.opaque_value, stamp: req_reg.now_seconds};

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        seq_next       = seq_reg;
        matched_next   = matched_reg;
        in_ready       = 1'b0;
        ctl            = '0;
        pos            = cnt_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next     = in_req;
                    res_next     = '0;
                    rem_next     = cnt_reg;
                    matched_next = 1'b0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (req_reg.kind == KIND_ALLOC || req_reg.kind == KIND_GENERATE)
                begin
                    res_next.tag_out = new_tag;
                    seq_next         = seq_reg + 15'd1;
                    if (req_reg.kind == KIND_ALLOC)
                    begin
                        if (is_full)
                        begin
                            res_next.full_flag = 1'b1;
                        end
                        else
                        begin
                            ctl.load = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    state_next = ST_FIN;
                end
                else if (req_reg.kind == KIND_FIND_TAG || req_reg.kind == KIND_FIND_OPAQUE
                         || req_reg.kind == KIND_FREE)
                begin
                    if (rem_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        pos        = IDX_W'(cnt_reg - CNT_W'(1));
                        ctl.rotate = 1'b1;
                        ctl.keep   = 1'b1;
                        rem_next   = rem_reg - CNT_W'(1);
                        if (req_reg.kind == KIND_FIND_TAG)
                        begin
                            if (!res_reg.found && head.tag == req_reg.tag_in)
                            begin
                                res_next.found      = 1'b1;
                                res_next.user_out   = head.user;
                                res_next.opaque_out = head.opaque;
                            end
                        end
                        else if (req_reg.kind == KIND_FIND_OPAQUE)
                        begin
                            if (!res_reg.found && head.opaque == req_reg.opaque_value)
                            begin
                                res_next.found    = 1'b1;
                                res_next.user_out = head.user;
                                res_next.tag_out  = head.tag;
                            end
                        end
                        else
                        begin
                            // drop the match, and expired entries ahead of it
                            if (!matched_reg && (head.tag == req_reg.tag_in || expired))
                            begin
                                ctl.keep = 1'b0;
                                cnt_next = cnt_reg - CNT_W'(1);
                                if (head.tag == req_reg.tag_in)
                                begin
                                    matched_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            seq_reg       <= SEQ_RESET;
            rem_reg       <= '0;
            matched_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            seq_reg       <= seq_next;
            rem_reg       <= rem_next;
            matched_reg   <= matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign count     = cnt_reg;

endmodule

// File: rtl/request_tag_table.sv
// top level of the request tag table: config register, sequencer and cell row
//
// The table is a row of TABLE_DEPTH cells kept in order from cell 0. Allocate,
// generate and the unused kinds pass from idle through the run state, which
// forms the result, to the finish state, which loads the result register;
// find by tag, find by opaque value and free stay in the run state while the
// stored entries are rotated once through cell 0, one entry per cycle, where
// they are compared and, for free, either kept or dropped. The result register
// is loaded only once the previous result has been taken. A new request is
// accepted in idle once the previous one has reached the result register,
// even if it has not been taken yet. No clearing pass is needed after reset.
module request_tag_table import rtt_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    rtt_req_if.sink     request,
    rtt_rsp_if.source   response,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [15:0]      expiry_reg;
    cell_ctl_t        ctl;
    logic [IDX_W-1:0] pos;
    entry_t           new_entry;
    logic [CNT_W-1:0] count;
    entry_t           cells [TABLE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= EXPIRY_RESET;
        end
        else if (cfg_wr_en)
        begin
            expiry_reg <= cfg_wr_data;
        end
    end

    rtt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_req    (request.payload),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .out_res   (response.payload),
        .expiry    (expiry_reg),
        .head      (cells[0]),
        .ctl       (ctl),
        .pos       (pos),
        .new_entry (new_entry),
        .count     (count)
    );

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        rtt_cell #(
            .INDEX (k),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .new_entry  (new_entry),
            .next_entry (cells[(k + 1) % TABLE_DEPTH]),
            .head_entry (cells[0]),
            .entry      (cells[k])
        );
    end

    // fill count stays within the row
    assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // one transaction at a time enters the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request accepted while busy");

    // allocate into a table with room appends exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.payload.kind == KIND_ALLOC
         && count < CNT_W'(TABLE_DEPTH))
        |-> ##2 (count == $past(count, 2) + CNT_W'(1)))
        else $error("allocate did not append an entry");

    // a result never reports both a match and a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> !(response.payload.found && response.payload.full_flag))
        else $error("found and full set together");

endmodule
